### design/qtbu_pkg.sv
// ----------------------------------------------------------------------------
// qtbu_pkg
// Shared constants for the Q-table backward update block: value format,
// action count, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package qtbu_pkg;

  // Q16.16 value width and action count.
  localparam int Q_W     = 32;
  localparam int ACTIONS = 3;
  localparam int ACT_W   = $clog2(ACTIONS);

  // Geometry default for the top level.
  localparam int SIDE_DEFAULT = 16;

  // Input coordinate width.
  localparam int POS_W = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TERMINAL_SCALE = 2'd2;

  localparam logic [15:0] LEARNING_RATE_RESET  = 16'd6554;
  localparam logic [16:0] DISCOUNT_RESET       = 17'd65536;
  localparam logic [15:0] TERMINAL_SCALE_RESET = 16'd1000;

endpackage

`default_nettype wire

### design/qtbu_ram.sv
// ----------------------------------------------------------------------------
// qtbu_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module qtbu_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/q_table_backward_update.sv
// ----------------------------------------------------------------------------
// q_table_backward_update
// Tabular Q-learning update, episode steps replayed newest first.
// ----------------------------------------------------------------------------
// Each accepted step passes through the states MAX, MUL1, TGT, DELTA, MUL2
// and WB before the next accept: the single table read port is used twice
// (later row, then current row) and one shared 33x18 multiplier is used
// twice (target product, then the learning-rate product), each followed by
// a register. The table is stored as SIDE^3 rows of three Q16.16 values, one
// row per state. After reset a clearing pass zeroes all SIDE^3 rows (4096 at
// SIDE = 16), one row per cycle, while in_stall stays high; configuration
// writes are taken at all times. A finished result waits in the output
// register, so the next step can be accepted while the previous beat is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module q_table_backward_update #(
  parameter int SIDE = qtbu_pkg::SIDE_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration
  input  wire logic                              cfg_write,
  input  wire logic [qtbu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [qtbu_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Step input
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              episode_start,
  input  wire logic [qtbu_pkg::POS_W-1:0]        pos_x,
  input  wire logic [qtbu_pkg::POS_W-1:0]        pos_y,
  input  wire logic [qtbu_pkg::POS_W-1:0]        pos_z,
  input  wire logic [qtbu_pkg::ACT_W-1:0]        chosen_action,
  input  wire logic signed [qtbu_pkg::Q_W-1:0]   step_reward,
  // Result output
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [qtbu_pkg::Q_W-1:0]        updated_value,
  output logic                                   saturated
);

  import qtbu_pkg::*;

  localparam int CW    = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int DEPTH = SIDE * SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int ROW_W = Q_W * ACTIONS;
  localparam int PW    = 51;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_MAX   = 8'b0000_0100,
    ST_MUL1  = 8'b0000_1000,
    ST_TGT   = 8'b0001_0000,
    ST_DELTA = 8'b0010_0000,
    ST_MUL2  = 8'b0100_0000,
    ST_WB    = 8'b1000_0000
  } state_t;

  function automatic logic [CW-1:0] clamp_pos(input logic [POS_W-1:0] c);
    if (int'(c) >= SIDE) begin
      return CW'(SIDE - 1);
    end
    return CW'(c);
  endfunction

  function automatic logic [AW-1:0] row_addr(input logic [CW-1:0] x,
                                             input logic [CW-1:0] y,
                                             input logic [CW-1:0] z);
    return AW'((int'(x) * SIDE + int'(y)) * SIDE + int'(z));
  endfunction

  state_t state, state_next;

  // Configuration registers
  logic [15:0] learning_rate;
  logic [16:0] discount;
  logic [15:0] terminal_scale;

  // Later step (the one handled just before)
  logic [CW-1:0]        later_x, later_y, later_z;
  logic signed [Q_W-1:0] later_reward;

  // Current step
  logic                  cur_start;
  logic [CW-1:0]         cur_x, cur_y, cur_z;
  logic [ACT_W-1:0]      cur_act;
  logic [AW-1:0]         cur_addr;
  logic signed [Q_W-1:0] cur_reward;

  // Datapath
  logic [AW-1:0]          clr_addr;
  logic signed [32:0]     mul_a;
  logic [16:0]            mul_b;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   prod_shift;
  logic signed [Q_W-1:0]  tgt;
  logic                   sat_tgt;
  logic signed [PW-1:0]   tgt_wide;
  logic signed [PW-1:0]   newq_wide;
  logic signed [Q_W-1:0]  newq;
  logic                   newq_sat;
  logic signed [Q_W-1:0]  lane_max;
  logic signed [Q_W-1:0]  q_cur;
  logic signed [Q_W-1:0]  rd_lane [ACTIONS];
  logic [ROW_W-1:0]       wr_row;

  // RAM ports
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [ROW_W-1:0] ram_rdata;

  logic accept;
  logic out_free;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    for (int i = 0; i < ACTIONS; i++) begin
      rd_lane[i] = ram_rdata[i*Q_W +: Q_W];
    end
  end

  assign q_cur = rd_lane[cur_act];

  always_comb begin
    lane_max = rd_lane[0];
    for (int i = 1; i < ACTIONS; i++) begin
      if (rd_lane[i] > lane_max) begin
        lane_max = rd_lane[i];
      end
    end
  end

  assign prod_shift = prod >>> 16;

  // Terminal target is the full product; otherwise reward plus scaled max.
  always_comb begin
    if (cur_start) begin
      tgt_wide = prod;
    end else begin
      tgt_wide = PW'(later_reward) + prod_shift;
    end
  end

  assign newq_wide = PW'(q_cur) + prod_shift;

  always_comb begin
    newq_sat = 1'b0;
    if (newq_wide > PW'(32'sh7FFF_FFFF)) begin
      newq     = 32'sh7FFF_FFFF;
      newq_sat = 1'b1;
    end else if (newq_wide < PW'(32'sh8000_0000)) begin
      newq     = 32'sh8000_0000;
      newq_sat = 1'b1;
    end else begin
      newq = newq_wide[Q_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < ACTIONS; i++) begin
      if (ACT_W'(i) == cur_act) begin
        wr_row[i*Q_W +: Q_W] = newq;
      end else begin
        wr_row[i*Q_W +: Q_W] = rd_lane[i];
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = wr_row;
    ram_raddr = cur_addr;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_raddr = row_addr(later_x, later_y, later_z);
      end
      ST_WB: begin
        ram_we = out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_MAX;
      ST_MAX:   state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_TGT;
      ST_TGT:   state_next = ST_DELTA;
      ST_DELTA: state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_WB;
      ST_WB:    if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      out_valid      <= 1'b0;
      learning_rate  <= LEARNING_RATE_RESET;
      discount       <= DISCOUNT_RESET;
      terminal_scale <= TERMINAL_SCALE_RESET;
      later_x        <= '0;
      later_y        <= '0;
      later_z        <= '0;
      later_reward   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_LEARNING_RATE:  learning_rate  <= cfg_data[15:0];
          REG_DISCOUNT:       discount       <= cfg_data;
          REG_TERMINAL_SCALE: terminal_scale <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      if (state == ST_WB && out_free) begin
        out_valid    <= 1'b1;
        later_x      <= cur_x;
        later_y      <= cur_y;
        later_z      <= cur_z;
        later_reward <= cur_reward;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_start  <= episode_start;
      cur_x      <= clamp_pos(pos_x);
      cur_y      <= clamp_pos(pos_y);
      cur_z      <= clamp_pos(pos_z);
      cur_addr   <= row_addr(clamp_pos(pos_x), clamp_pos(pos_y), clamp_pos(pos_z));
      cur_act    <= (chosen_action > ACT_W'(ACTIONS - 1)) ? ACT_W'(ACTIONS - 1)
                                                          : chosen_action;
      cur_reward <= step_reward;
    end
    case (state)
      ST_MAX: begin
        if (cur_start) begin
          mul_a <= 33'(cur_reward);
          mul_b <= {1'b0, terminal_scale};
        end else begin
          mul_a <= 33'(lane_max);
          mul_b <= discount;
        end
      end
      ST_MUL1, ST_MUL2: begin
        prod <= PW'(mul_a * $signed({1'b0, mul_b}));
      end
      ST_TGT: begin
        if (tgt_wide > PW'(32'sh7FFF_FFFF)) begin
          tgt     <= 32'sh7FFF_FFFF;
          sat_tgt <= 1'b1;
        end else if (tgt_wide < PW'(32'sh8000_0000)) begin
          tgt     <= 32'sh8000_0000;
          sat_tgt <= 1'b1;
        end else begin
          tgt     <= tgt_wide[Q_W-1:0];
          sat_tgt <= 1'b0;
        end
      end
      ST_DELTA: begin
        mul_a <= 33'(tgt) - 33'(q_cur);
        mul_b <= {1'b0, learning_rate};
      end
      ST_WB: begin
        if (out_free) begin
          updated_value <= newq;
          saturated     <= sat_tgt | newq_sat;
        end
      end
      default: begin
      end
    endcase
  end

  qtbu_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

### design/qtbu_checker.sv
// ----------------------------------------------------------------------------
// qtbu_checker
// Port-level checks for the Q-table backward update block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module qtbu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] updated_value,
  input wire logic        saturated
);

  // Reset starts the clearing pass, so no step may enter right after it.
  a_reset_stalls: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present after reset");

  // A step occupies the sequencer for several cycles before the next one.
  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall
                                ##1 in_stall ##1 in_stall)
    else $error("step accepted while the previous one is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(updated_value)
                                 && $stable(saturated))
    else $error("stalled result beat changed");

endmodule

bind q_table_backward_update qtbu_checker u_qtbu_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .updated_value (updated_value),
  .saturated     (saturated)
);

`default_nettype wire
